FILE: src/imu_bias_calibrate_and_scale_unit_defines.svh
// ----------------------------------------------------------------------------
// IMU bias calibration - assertion macros
// Shared concurrent assertion forms; they expect aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef IMU_BIAS_CALIBRATE_AND_SCALE_UNIT_DEFINES_SVH
`define IMU_BIAS_CALIBRATE_AND_SCALE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IMUBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IMUBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/imubc_pkg.sv
// ----------------------------------------------------------------------------
// IMU bias calibration - package
// Widths, scaling constants and the control types shared by the lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imubc_pkg;

    // Number of bias-corrected axes (ax, ay, az, gx, gy, gz)
    localparam int AXES       = 6;
    localparam int RAW_W      = 16;
    localparam int ADD_W      = 17;   // raw sample with 1 g taken off z
    localparam int SUM_W      = 24;
    localparam int OFS_W      = 21;
    localparam int DIFF_W     = 22;   // raw*16 - offset
    localparam int NUM_W      = SUM_W + 6;  // sum*32 + CAL_SAMPLES, signed
    localparam int MAG_W      = NUM_W - 1;  // magnitude fed to the divider
    localparam int DIV_STEPS  = 1;          // reciprocal multiply, then commit
    localparam int DIV_CNT_W  = 1;
    localparam int TEMP_W     = 17;

    // 1 g in raw accel counts
    localparam logic signed [ADD_W-1:0] ONE_G_RAW = 17'sd2048;

    // Gyro: (raw*16 - offset) * 63937 >> 16
    localparam int GYRO_MUL_W = 17;
    localparam int GPROD_W    = DIFF_W + GYRO_MUL_W;
    localparam int GYRO_SHIFT = 16;
    localparam logic signed [GYRO_MUL_W-1:0] GYRO_MUL = 17'sd63937;

    // Temperature: t is biased by 85*386 so it can be split as 85*k + j.
    // Result is 64*k + floor((640*j + 153)/850) - 15352.
    localparam int TU_W            = 17;
    localparam int KQ_W            = 10;
    localparam int KPROD_W         = 41;
    localparam int XT_W            = 16;
    localparam int XW_W            = 27;
    localparam int FQ_W            = 6;
    localparam int FPROD_W         = 43;
    localparam logic [17:0] TEMP_BIAS     = 18'd32810;
    localparam logic [23:0] RECIP_85      = 24'd12632257;
    localparam int          RECIP_85_SH   = 30;
    localparam logic [XW_W-1:0] TEMP_MUL  = 27'd640;
    localparam logic [XW_W-1:0] TEMP_RND  = 27'd153;
    localparam logic [XW_W-1:0] TEMP_STEP = 27'd54400;
    localparam logic [26:0] RECIP_850     = 27'd80846444;
    localparam int          RECIP_850_SH  = 36;
    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 17'sd15352;

    // Calibration sequencer states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_CAL,
        ST_DIV
    } ctrl_state_t;

    // Controls broadcast from the sequencer to every lane
    typedef struct packed {
        logic clear;       // zero sums and offsets
        logic acc;         // add this item into the sums
        logic div_load;    // load divider from the updated sum
        logic div_step;    // reciprocal multiply into the quotient register
        logic div_commit;  // write quotient into the offset
    } lane_ctrl_t;

endpackage

FILE: src/imubc_ctrl.sv
// ----------------------------------------------------------------------------
// IMU bias calibration - sequencer
// Tracks start commands, counts calibration items and paces the lane dividers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imu_bias_calibrate_and_scale_unit_defines.svh"

module imubc_ctrl #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 cmd,
    output imubc_pkg::lane_ctrl_t lane_ctrl,
    output logic                 busy,
    output logic                 calibrating,
    output logic                 cal_done
);
    import imubc_pkg::*;

    localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS);

    ctrl_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 cal_done_reg, cal_done_next;
    logic                 count_last;
    logic                 start_ok;

    assign count_last = (count_reg == CNT_LAST);
    assign start_ok   = accept && cmd && !cal_done_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (start_ok) state_next = ST_CAL;
            end
            ST_CAL: begin
                if (accept && !cmd && count_last) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_LAST) state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Outputs to the lanes
    always_comb begin
        lane_ctrl = '0;
        unique case (state_reg)
            ST_RUN: begin
                lane_ctrl.clear = start_ok;
            end
            ST_CAL: begin
                lane_ctrl.clear    = start_ok;
                lane_ctrl.acc      = accept && !cmd;
                lane_ctrl.div_load = accept && !cmd && count_last;
            end
            ST_DIV: begin
                lane_ctrl.div_step   = (div_cnt_reg != DIV_LAST);
                lane_ctrl.div_commit = (div_cnt_reg == DIV_LAST);
            end
            default: lane_ctrl = '0;
        endcase
    end

    // Item and division step counters, calibrated flag
    always_comb begin
        count_next    = count_reg;
        div_cnt_next  = div_cnt_reg;
        cal_done_next = cal_done_reg;
        if (lane_ctrl.clear) begin
            count_next = '0;
        end else if (lane_ctrl.acc) begin
            count_next = count_last ? '0 : count_reg + 1'b1;
        end
        if (lane_ctrl.div_load) begin
            div_cnt_next = '0;
        end else if (lane_ctrl.div_step) begin
            div_cnt_next = div_cnt_reg + 1'b1;
        end
        if (lane_ctrl.div_commit) cal_done_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            count_reg    <= '0;
            div_cnt_reg  <= '0;
            cal_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            div_cnt_reg  <= div_cnt_next;
            cal_done_reg <= cal_done_next;
        end
    end

    assign busy        = (state_reg == ST_DIV);
    assign calibrating = (state_reg == ST_CAL);
    assign cal_done    = cal_done_reg;

    // Checks
    `IMUBC_ASSERT_NOW(a_no_accept_while_div, accept, state_reg != ST_DIV, "item taken during divide")
    `IMUBC_ASSERT_NEXT(a_commit_sets_done, lane_ctrl.div_commit, cal_done_reg && state_reg == ST_RUN, "commit did not finish calibration")
    `IMUBC_ASSERT_NOW(a_done_stays_run, cal_done_reg, state_reg == ST_RUN, "calibrated block left run state")
    `IMUBC_ASSERT_NOW(a_count_idle_zero, state_reg != ST_CAL, count_reg == '0, "item count not cleared outside calibration")

endmodule

FILE: src/imubc_lane.sv
// ----------------------------------------------------------------------------
// IMU bias calibration - axis lane
// Per-axis sum, offset divider and bias-corrected difference register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imubc_lane #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  imubc_pkg::lane_ctrl_t                     lane_ctrl,
    input  logic                                      s1_en,
    input  logic signed [imubc_pkg::RAW_W-1:0]        raw,
    input  logic signed [imubc_pkg::ADD_W-1:0]        addend,
    output logic signed [imubc_pkg::DIFF_W-1:0]       diff
);
    import imubc_pkg::*;

    localparam int DIVISOR = 2 * CAL_SAMPLES;
    localparam int REC_L   = $clog2(DIVISOR);
    localparam int QSH     = MAG_W + REC_L;
    localparam int PROD_W  = 2 * MAG_W + 1;
    localparam longint RECIP_L = ((longint'(1) << QSH) / longint'(DIVISOR)) + longint'(1);
    localparam logic [MAG_W:0]          RECIP_K  = (MAG_W + 1)'(RECIP_L);
    localparam logic signed [NUM_W-1:0] ROUND_K  = NUM_W'(CAL_SAMPLES);
    localparam logic [MAG_W-1:0]        NEG_ADJ  = MAG_W'(DIVISOR - 1);

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [OFS_W-1:0]  offset_reg, offset_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [MAG_W-1:0]         quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic signed [DIFF_W-1:0] diff_reg;

    logic signed [SUM_W-1:0]  sum_acc;
    logic signed [NUM_W-1:0]  num;
    logic signed [NUM_W-1:0]  num_neg;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        quo_prod;
    logic [PROD_W-1:0]        quo_shr;
    logic [MAG_W-1:0]         quo_neg;
    logic [DIFF_W-1:0]        raw_x16;
    logic [DIFF_W-1:0]        ofs_ext;

    // Running sum, wraps at SUM_W
    assign sum_acc = sum_reg + {{(SUM_W - ADD_W){addend[ADD_W-1]}}, addend};

    // Rounded average numerator and its magnitude for floor division
    assign num     = {sum_acc[SUM_W-1], sum_acc, 5'b0} + ROUND_K;
    assign num_neg = -num;
    assign mag     = num[NUM_W-1] ? (num_neg[MAG_W-1:0] + NEG_ADJ) : num[MAG_W-1:0];

    // Quotient by reciprocal multiply, exact for any MAG_W-bit magnitude
    assign quo_prod = PROD_W'(mag_reg) * PROD_W'(RECIP_K);
    assign quo_shr  = quo_prod >> QSH;
    assign quo_neg  = -quo_reg;

    always_comb begin
        sum_next    = sum_reg;
        offset_next = offset_reg;
        mag_next    = mag_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        if (lane_ctrl.clear) begin
            sum_next    = '0;
            offset_next = '0;
        end else if (lane_ctrl.acc) begin
            sum_next = sum_acc;
        end
        if (lane_ctrl.div_load) begin
            mag_next = mag;
            neg_next = num[NUM_W-1];
        end
        if (lane_ctrl.div_step) begin
            quo_next = quo_shr[MAG_W-1:0];
        end
        if (lane_ctrl.div_commit) begin
            offset_next = neg_reg ? quo_neg[OFS_W-1:0] : quo_reg[OFS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end else begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
    end

    // Divider datapath
    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // First pipeline stage: raw*16 - offset
    assign raw_x16 = {{(DIFF_W - RAW_W - 4){raw[RAW_W-1]}}, raw, 4'b0};
    assign ofs_ext = {{(DIFF_W - OFS_W){offset_reg[OFS_W-1]}}, offset_reg};

    always_ff @(posedge aclk) begin
        if (s1_en) diff_reg <= raw_x16 - ofs_ext;
    end

    assign diff = diff_reg;

endmodule

FILE: src/imubc_temp.sv
// ----------------------------------------------------------------------------
// IMU bias calibration - temperature path
// Converts raw die temperature to 1/256 degree C by two reciprocal multiplies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imubc_temp (
    input  logic                                 aclk,
    input  logic                                 s1_en,
    input  logic                                 s2_en,
    input  logic signed [imubc_pkg::RAW_W-1:0]   temp_raw,
    output logic signed [imubc_pkg::TEMP_W-1:0]  temp_c
);
    import imubc_pkg::*;

    logic [17:0]          tu_wide;
    logic [TU_W-1:0]      tu;
    logic [KPROD_W-1:0]   kprod;
    logic [TU_W-1:0]      tu1_reg;
    logic [KQ_W-1:0]      k1_reg;
    logic [XW_W-1:0]      x_wide;
    logic [XT_W-1:0]      x2_reg;
    logic [KQ_W-1:0]      k2_reg;
    logic [FPROD_W-1:0]   fprod;
    logic [FQ_W-1:0]      frac;

    // Stage 1: bias to non-negative, quotient by 85
    assign tu_wide = {{2{temp_raw[RAW_W-1]}}, temp_raw} + TEMP_BIAS;
    assign tu      = tu_wide[TU_W-1:0];
    assign kprod   = KPROD_W'(tu) * KPROD_W'(RECIP_85);

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            tu1_reg <= tu;
            k1_reg  <= kprod[RECIP_85_SH + KQ_W - 1:RECIP_85_SH];
        end
    end

    // Stage 2: 640*(t mod 85) + 153, formed without the remainder
    assign x_wide = XW_W'(tu1_reg) * TEMP_MUL + TEMP_RND - XW_W'(k1_reg) * TEMP_STEP;

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            x2_reg <= x_wide[XT_W-1:0];
            k2_reg <= k1_reg;
        end
    end

    // Stage 3 (registered by the merge): fractional part by 850, then assemble
    assign fprod  = FPROD_W'(x2_reg) * FPROD_W'(RECIP_850);
    assign frac   = fprod[RECIP_850_SH + FQ_W - 1:RECIP_850_SH];
    assign temp_c = $signed({1'b0, k2_reg, frac}) - TEMP_BASE;

endmodule

FILE: src/imu_bias_calibrate_and_scale_unit.sv
// ----------------------------------------------------------------------------
// IMU bias calibration and scale unit - top level
// Six axis lanes plus a temperature path feed a merge stage and output register.
// ----------------------------------------------------------------------------
// Pipeline: an item that emits passes stage 1, stage 2 and the output register.
// Throughput: one item per cycle while m_ready does not hold the output; the input
//   also stalls after the last calibration item, while each lane forms its offset
//   by a reciprocal multiply and then commits it.
// Reset: aresetn (synchronous, active low) clears sums, offsets, the item
//   count, the calibrated flag and all valid flags.
`timescale 1ns / 1ps

module imu_bias_calibrate_and_scale_unit #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [15:0] s_accel_x_raw,
    input  logic signed [15:0] s_accel_y_raw,
    input  logic signed [15:0] s_accel_z_raw,
    input  logic signed [15:0] s_temp_raw,
    input  logic signed [15:0] s_gyro_x_raw,
    input  logic signed [15:0] s_gyro_y_raw,
    input  logic signed [15:0] s_gyro_z_raw,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [20:0] m_accel_x,
    output logic signed [20:0] m_accel_y,
    output logic signed [20:0] m_accel_z,
    output logic signed [16:0] m_temp_c,
    output logic signed [20:0] m_gyro_x,
    output logic signed [20:0] m_gyro_y,
    output logic signed [20:0] m_gyro_z,
    output logic               m_is_calibrated
);
    import imubc_pkg::*;

    localparam int HALF = AXES / 2;

    lane_ctrl_t               lane_ctrl;
    logic                     busy;
    logic                     calibrating;
    logic                     cal_done;
    logic                     accept;
    logic                     emit;
    logic                     en1, en2, en3;
    logic                     v1_reg, v2_reg, m_valid_reg;
    logic                     cal1_reg, cal2_reg;

    logic signed [RAW_W-1:0]  lane_raw    [AXES];
    logic signed [ADD_W-1:0]  lane_add    [AXES];
    logic signed [DIFF_W-1:0] lane_diff   [AXES];
    logic signed [GPROD_W-1:0] gprod      [HALF];
    logic [OFS_W-1:0]         accel2_reg  [HALF];
    logic [OFS_W-1:0]         gyro2_reg   [HALF];
    logic signed [TEMP_W-1:0] temp_c;

    logic signed [OFS_W-1:0]  accel_x_reg, accel_y_reg, accel_z_reg;
    logic signed [OFS_W-1:0]  gyro_x_reg, gyro_y_reg, gyro_z_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     is_cal_reg;

    // Pipeline advance: a stage moves when its successor is empty or moving
    assign en3     = !m_valid_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1 && !busy;
    assign accept  = s_valid && s_ready;
    assign emit    = accept && !s_cmd && !calibrating;

    // Calibration sequencer
    imubc_ctrl #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_cmd),
        .lane_ctrl   (lane_ctrl),
        .busy        (busy),
        .calibrating (calibrating),
        .cal_done    (cal_done)
    );

    // Lane inputs; z loses 1 g while calibrating
    assign lane_raw[0] = s_accel_x_raw;
    assign lane_raw[1] = s_accel_y_raw;
    assign lane_raw[2] = s_accel_z_raw;
    assign lane_raw[3] = s_gyro_x_raw;
    assign lane_raw[4] = s_gyro_y_raw;
    assign lane_raw[5] = s_gyro_z_raw;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            lane_add[i] = {lane_raw[i][RAW_W-1], lane_raw[i]};
        end
        lane_add[2] = {s_accel_z_raw[RAW_W-1], s_accel_z_raw} - ONE_G_RAW;
    end

    // Axis lanes
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        imubc_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lane_ctrl (lane_ctrl),
            .s1_en     (en1),
            .raw       (lane_raw[g]),
            .addend    (lane_add[g]),
            .diff      (lane_diff[g])
        );
    end

    // Temperature path
    imubc_temp u_temp (
        .aclk     (aclk),
        .s1_en    (en1),
        .s2_en    (en2),
        .temp_raw (s_temp_raw),
        .temp_c   (temp_c)
    );

    // Stage 2: gyro scaling by 63937/65536, accel passes through
    for (genvar g = 0; g < HALF; g++) begin : g_scale
        assign gprod[g] = lane_diff[g + HALF] * GYRO_MUL;

        always_ff @(posedge aclk) begin
            if (en2) begin
                accel2_reg[g] <= lane_diff[g][OFS_W-1:0];
                gyro2_reg[g]  <= gprod[g][GYRO_SHIFT + OFS_W - 1:GYRO_SHIFT];
            end
        end
    end

    // Calibrated flag travels with each item
    always_ff @(posedge aclk) begin
        if (en1) cal1_reg <= cal_done;
        if (en2) cal2_reg <= cal1_reg;
    end

    // Merge stage: output register
    always_ff @(posedge aclk) begin
        if (en3) begin
            accel_x_reg <= accel2_reg[0];
            accel_y_reg <= accel2_reg[1];
            accel_z_reg <= accel2_reg[2];
            gyro_x_reg  <= gyro2_reg[0];
            gyro_y_reg  <= gyro2_reg[1];
            gyro_z_reg  <= gyro2_reg[2];
            temp_reg    <= temp_c;
            is_cal_reg  <= cal2_reg;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= emit;
            if (en2) v2_reg      <= v1_reg;
            if (en3) m_valid_reg <= v2_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accel_x       = accel_x_reg;
    assign m_accel_y       = accel_y_reg;
    assign m_accel_z       = accel_z_reg;
    assign m_temp_c        = temp_reg;
    assign m_gyro_x        = gyro_x_reg;
    assign m_gyro_y        = gyro_y_reg;
    assign m_gyro_z        = gyro_z_reg;
    assign m_is_calibrated = is_cal_reg;

endmodule
